// ===== design/psg3_pkg.sv =====
// ----------------------------------------------------------------------------
// psg3_pkg
// Shared codes, register indexes, types and the volume table of the
// three-channel tone, noise and envelope sound generator.
// ----------------------------------------------------------------------------
package psg3_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_SELECT = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Register map.
  localparam logic [3:0] REG_NOISE  = 4'd6;
  localparam logic [3:0] REG_MIXER  = 4'd7;
  localparam logic [3:0] REG_VOL0   = 4'd8;
  localparam logic [3:0] REG_ENV_LO = 4'd11;
  localparam logic [3:0] REG_ENV_HI = 4'd12;
  localparam logic [3:0] REG_SHAPE  = 4'd13;

  localparam int NUM_CH = 3;

  typedef logic [7:0] byte_t;

  // Controls handed to the envelope generator for one item.
  typedef struct packed {
    logic tick;
    logic restart;
    logic attack;
    logic cont;
    logic alt;
    logic hold;
  } env_ctl_t;

  function automatic logic [5:0] vol_lookup(input logic [3:0] lv);
    logic [5:0] v;
    case (lv)
      4'd0:    v = 6'd0;
      4'd1:    v = 6'd1;
      4'd2:    v = 6'd2;
      4'd3:    v = 6'd3;
      4'd4:    v = 6'd4;
      4'd5:    v = 6'd5;
      4'd6:    v = 6'd7;
      4'd7:    v = 6'd10;
      4'd8:    v = 6'd13;
      4'd9:    v = 6'd18;
      4'd10:   v = 6'd24;
      4'd11:   v = 6'd30;
      4'd12:   v = 6'd36;
      4'd13:   v = 6'd40;
      4'd14:   v = 6'd42;
      default: v = 6'd42;
    endcase
    return v;
  endfunction

endpackage

// ===== design/psg3_tone.sv =====
// ----------------------------------------------------------------------------
// psg3_tone
// One 12-bit tone divider: counts ticks and toggles its square-wave level
// each time the count reaches the period.
// ----------------------------------------------------------------------------
module psg3_tone (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic [11:0] period,
  output logic        level_next
);

  logic [11:0] cnt;
  logic [11:0] cnt_next;
  logic [11:0] cnt_inc;
  logic        level;

  always_comb begin
    cnt_inc    = cnt + 12'd1;
    cnt_next   = cnt;
    level_next = level;
    if (tick) begin
      // A period shortened below the count expires on the next tick.
      if (cnt_inc >= period) begin
        cnt_next   = '0;
        level_next = ~level;
      end else begin
        cnt_next = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      level <= 1'b0;
    end else begin
      cnt   <= cnt_next;
      level <= level_next;
    end
  end

endmodule

// ===== design/psg3_noise.sv =====
// ----------------------------------------------------------------------------
// psg3_noise
// Noise source: a 17-bit shift register with feedback from bits 0 and 3,
// shifted once every twice the noise period in ticks.
// ----------------------------------------------------------------------------
module psg3_noise (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic [4:0] period,
  output logic       level_next
);

  logic [5:0]  cnt;
  logic [5:0]  cnt_next;
  logic [5:0]  cnt_inc;
  logic [16:0] shifter;
  logic [16:0] shifter_next;
  logic        level;

  always_comb begin
    cnt_inc      = cnt + 6'd1;
    cnt_next     = cnt;
    shifter_next = shifter;
    level_next   = level;
    if (tick) begin
      if (cnt_inc >= {period, 1'b0}) begin
        cnt_next     = '0;
        shifter_next = {shifter[0] ^ shifter[3], shifter[16:1]};
        level_next   = shifter_next[0];
      end else begin
        cnt_next = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      shifter <= 17'd1;
      level   <= 1'b0;
    end else begin
      cnt     <= cnt_next;
      shifter <= shifter_next;
      level   <= level_next;
    end
  end

endmodule

// ===== design/psg3_env.sv =====
// ----------------------------------------------------------------------------
// psg3_env
// Envelope generator: sixteen level steps, one every 32 times the envelope
// period in ticks, with continue, alternate, hold and attack modes.
// ----------------------------------------------------------------------------
module psg3_env (
  input  logic                clk,
  input  logic                rst,
  input  psg3_pkg::env_ctl_t  ctl,
  input  logic [15:0]         period,
  output logic [3:0]          level_next
);
  import psg3_pkg::*;

  logic [20:0] cnt;
  logic [20:0] cnt_next;
  logic [20:0] cnt_inc;
  logic [4:0]  step;
  logic [4:0]  step_next;
  logic        rising;
  logic        rising_next;
  logic [3:0]  level;

  always_comb begin
    cnt_inc     = cnt + 21'd1;
    cnt_next    = cnt;
    step_next   = step;
    rising_next = rising;
    level_next  = level;
    if (ctl.restart) begin
      cnt_next    = '0;
      step_next   = '0;
      rising_next = ctl.attack;
      level_next  = ctl.attack ? 4'd0 : 4'd15;
    end else if (ctl.tick) begin
      if (cnt_inc >= {period, 5'b0}) begin
        cnt_next = '0;
        if (!step[4]) begin
          level_next = rising ? step[3:0] : ~step[3:0];
          step_next  = step + 5'd1;
        end else if (!ctl.cont) begin
          level_next = 4'd0;
        end else if (ctl.hold) begin
          level_next = (rising ^ ctl.alt) ? 4'd15 : 4'd0;
        end else begin
          // End of a cycle without hold: start again, turned round if alternating.
          rising_next = rising ^ ctl.alt;
          step_next   = '0;
          level_next  = rising_next ? 4'd0 : 4'd15;
        end
      end else begin
        cnt_next = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      step   <= '0;
      rising <= 1'b0;
      level  <= '0;
    end else begin
      cnt    <= cnt_next;
      step   <= step_next;
      rising <= rising_next;
      level  <= level_next;
    end
  end

`ifndef SYNTHESIS
  // The step counter never runs past the end of a cycle.
  a_step_range: assert property (@(posedge clk) disable iff (rst) step <= 5'd16)
    else $error("envelope step out of range");
`endif

endmodule

// ===== design/three_channel_tone_noise_envelope_psg.sv =====
// ----------------------------------------------------------------------------
// three_channel_tone_noise_envelope_psg
// Programmable sound generator with sixteen byte registers, three tone
// channels, a noise source and an envelope generator; every beat returns the
// selected register's byte and the summed channel amplitude.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------
//   item     | item_valid / item_stall    | opcode[1:0], data[7:0]
//   result   | result_valid / result_stall| read_data[7:0], amplitude[6:0]
//
// One item a cycle is sustained while the result side does not stall; a
// result passes through the input register, then the result register,
// before it can be taken.
// The register file, the dividers and the envelope update in the single
// stage between those two registers.
// rst is synchronous, active high, and resets all but the data registers.
// A stalled result holds the stage; item_stall rises only when both the
// input register and the result register are full.
// ----------------------------------------------------------------------------
module three_channel_tone_noise_envelope_psg (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] data,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] read_data,
  output logic [6:0] amplitude
);
  import psg3_pkg::*;

  // Input register.
  logic       q_valid;
  logic [1:0] q_opcode;
  logic [7:0] q_data;
  logic       adv;

  // Register file and selection.
  byte_t      regs [16];
  byte_t      regs_next [16];
  logic [3:0] sel;
  logic [3:0] sel_next;
  logic       do_write;
  logic       do_tick;

  logic [11:0]       tone_period [NUM_CH];
  logic [NUM_CH-1:0] tone_lvl_next;
  logic [4:0]        noise_period;
  logic              noise_lvl_next;
  logic [15:0]       env_period;
  logic [3:0]        env_lvl_next;
  env_ctl_t          env_ctl;
  logic [6:0]        amp_next;

  assign adv        = q_valid && (!result_valid || !result_stall);
  assign item_stall = q_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!item_stall) begin
      q_valid <= item_valid;
    end
    if (!item_stall && item_valid) begin
      q_opcode <= opcode;
      q_data   <= data;
    end
  end

  always_comb begin
    sel_next  = sel;
    do_write  = 1'b0;
    do_tick   = 1'b0;
    regs_next = regs;
    if (adv) begin
      case (q_opcode)
        OP_SELECT: sel_next = q_data[3:0];
        OP_WRITE:  do_write = 1'b1;
        OP_READ:   ;
        OP_TICK:   do_tick  = 1'b1;
        default:   ;
      endcase
    end
    if (do_write) begin
      regs_next[sel] = q_data;
    end
  end

  // Periods follow the stored registers; a zero period counts as one.
  // Writes and ticks never share an item, so the current registers serve.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      tone_period[c] = {regs[2*c+1][3:0], regs[2*c]};
      if (tone_period[c] == '0) begin
        tone_period[c] = 12'd1;
      end
    end
    noise_period = regs[REG_NOISE][4:0];
    if (noise_period == '0) begin
      noise_period = 5'd1;
    end
    env_period = {regs[REG_ENV_HI], regs[REG_ENV_LO]};
    if (env_period == '0) begin
      env_period = 16'd1;
    end
  end

  always_comb begin
    env_ctl.tick    = do_tick;
    env_ctl.restart = do_write && (sel == REG_SHAPE);
    env_ctl.attack  = q_data[2];
    env_ctl.cont    = regs[REG_SHAPE][3];
    env_ctl.alt     = regs[REG_SHAPE][1];
    env_ctl.hold    = regs[REG_SHAPE][0];
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_tone
    psg3_tone u_tone (
      .clk        (clk),
      .rst        (rst),
      .tick       (do_tick),
      .period     (tone_period[c]),
      .level_next (tone_lvl_next[c])
    );
  end

  psg3_noise u_noise (
    .clk        (clk),
    .rst        (rst),
    .tick       (do_tick),
    .period     (noise_period),
    .level_next (noise_lvl_next)
  );

  psg3_env u_env (
    .clk        (clk),
    .rst        (rst),
    .ctl        (env_ctl),
    .period     (env_period),
    .level_next (env_lvl_next)
  );

  // Mixer: a channel sounds when both its tone and noise gates are open.
  always_comb begin
    logic       tone_open;
    logic       noise_open;
    logic [7:0] vr;
    logic [3:0] lv;
    amp_next = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      tone_open  = regs_next[REG_MIXER][c] || tone_lvl_next[c];
      noise_open = regs_next[REG_MIXER][c+3] || noise_lvl_next;
      vr         = regs_next[REG_VOL0 + 4'(c)];
      lv         = vr[4] ? env_lvl_next : vr[3:0];
      if (tone_open && noise_open) begin
        amp_next = amp_next + 7'(vol_lookup(lv));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{default: '0};
      sel  <= '0;
    end else begin
      regs <= regs_next;
      sel  <= sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (adv) begin
      read_data <= regs_next[sel_next];
      amplitude <= amp_next;
    end
  end

`ifndef SYNTHESIS
  a_amp_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> amplitude <= 7'd126)
    else $error("amplitude beyond three full-scale channels");

  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> result_valid)
    else $error("processed beat did not reach the result register");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (q_valid && result_valid && result_stall))
    else $error("input stalled while the pipeline had room");
`endif

endmodule

// ===== tb/three_channel_tone_noise_envelope_psg_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_tone_noise_envelope_psg_tb
// Drives select, write, read and tick beats into the sound generator and
// checks every result beat against a cycle-free model of its registers,
// tone dividers, noise shifter and envelope, with random idling on both sides.
// ----------------------------------------------------------------------------
module three_channel_tone_noise_envelope_psg_tb;
  import psg3_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_TICKS = 8;

  localparam logic [3:0] REG_TONE_LO0 = 4'd0;
  localparam logic [3:0] REG_TONE_HI0 = 4'd1;

  localparam int SHAPE_HOLD   = 0;
  localparam int SHAPE_ALT    = 1;
  localparam int SHAPE_ATTACK = 2;
  localparam int SHAPE_CONT   = 3;
  localparam int VOL_USE_ENV  = 4;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] amplitude;
  } psg_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] opcode = OP_READ;
  logic [7:0] data = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] read_data;
  logic [6:0] amplitude;

  three_channel_tone_noise_envelope_psg dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .data         (data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .read_data    (read_data),
    .amplitude    (amplitude)
  );

  always #2ns clk = ~clk;

  // Model of the generator's state.
  byte_t       psg_regs [16];
  logic [3:0]  psg_sel;
  logic [11:0] tone_cnt [NUM_CH];
  logic [11:0] tone_per [NUM_CH];
  logic        tone_lvl [NUM_CH];
  logic [5:0]  noise_cnt;
  logic [4:0]  noise_per;
  logic [16:0] noise_lfsr;
  logic        noise_lvl;
  logic [20:0] env_cnt;
  logic [15:0] env_per;
  logic [4:0]  env_step;
  logic        env_up;
  logic [3:0]  env_lvl;
  int          vol_steps [16];

  psg_result_t expected_results [$];
  int          failures = 0;
  int          beats_sent = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  logic        source_gaps = 1'b0;
  logic        sink_gaps = 1'b0;

  task automatic model_reset();
    for (int i = 0; i < 16; i++) psg_regs[i] = 8'h00;
    psg_sel = 4'd0;
    for (int c = 0; c < NUM_CH; c++) begin
      tone_cnt[c] = 12'd0;
      tone_per[c] = 12'd1;
      tone_lvl[c] = 1'b0;
    end
    noise_cnt  = 6'd0;
    noise_per  = 5'd1;
    noise_lfsr = 17'd1;
    noise_lvl  = 1'b0;
    env_cnt    = 21'd0;
    env_per    = 16'd1;
    env_step   = 5'd0;
    env_up     = 1'b0;
    env_lvl    = 4'd0;
  endtask

  task automatic model_store(input logic [3:0] idx, input byte_t v);
    int          ch;
    logic [11:0] tp;
    logic [15:0] ep;
    psg_regs[idx] = v;
    if (idx < REG_NOISE) begin
      ch = idx >> 1;
      tp = {psg_regs[2 * ch + 1][3:0], psg_regs[2 * ch]};
      tone_per[ch] = (tp == 12'd0) ? 12'd1 : tp;
    end else if (idx == REG_NOISE) begin
      noise_per = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
    end else if (idx == REG_ENV_LO || idx == REG_ENV_HI) begin
      ep = {psg_regs[REG_ENV_HI], psg_regs[REG_ENV_LO]};
      env_per = (ep == 16'd0) ? 16'd1 : ep;
    end else if (idx == REG_SHAPE) begin
      env_step = 5'd0;
      env_cnt  = 21'd0;
      env_up   = v[SHAPE_ATTACK];
      env_lvl  = v[SHAPE_ATTACK] ? 4'd0 : 4'd15;
    end
  endtask

  task automatic model_tick();
    logic  fb;
    byte_t shape;
    for (int c = 0; c < NUM_CH; c++) begin
      tone_cnt[c] = tone_cnt[c] + 12'd1;
      if (tone_cnt[c] >= tone_per[c]) begin
        tone_cnt[c] = 12'd0;
        tone_lvl[c] = ~tone_lvl[c];
      end
    end
    noise_cnt = noise_cnt + 6'd1;
    if (noise_cnt >= {noise_per, 1'b0}) begin
      fb = noise_lfsr[0] ^ noise_lfsr[3];
      noise_cnt  = 6'd0;
      noise_lfsr = {fb, noise_lfsr[16:1]};
      noise_lvl  = noise_lfsr[0];
    end
    env_cnt = env_cnt + 21'd1;
    if (env_cnt >= {env_per, 5'b00000}) begin
      shape   = psg_regs[REG_SHAPE];
      env_cnt = 21'd0;
      if (env_step < 5'd16) begin
        env_lvl  = env_up ? env_step[3:0] : 4'd15 - env_step[3:0];
        env_step = env_step + 5'd1;
      end else if (!shape[SHAPE_CONT]) begin
        env_lvl = 4'd0;
      end else if (shape[SHAPE_HOLD]) begin
        env_lvl = (env_up ^ shape[SHAPE_ALT]) ? 4'd15 : 4'd0;
      end else begin
        // The cycle starts again, turning round when alternate is set.
        if (shape[SHAPE_ALT]) env_up = ~env_up;
        env_step = 5'd0;
        env_lvl  = env_up ? 4'd0 : 4'd15;
      end
    end
  endtask

  function automatic logic [6:0] model_amplitude();
    int         sum;
    byte_t      mix;
    byte_t      vr;
    logic [3:0] lv;
    sum = 0;
    mix = psg_regs[REG_MIXER];
    for (int c = 0; c < NUM_CH; c++) begin
      vr = psg_regs[REG_VOL0 + c];
      if ((mix[c] | tone_lvl[c]) && (mix[c + 3] | noise_lvl)) begin
        lv = vr[VOL_USE_ENV] ? env_lvl : vr[3:0];
        sum += vol_steps[lv];
      end
    end
    return 7'(sum);
  endfunction

  task automatic model_apply(input logic [1:0] op, input byte_t d, output psg_result_t r);
    case (op)
      OP_SELECT: psg_sel = d[3:0];
      OP_WRITE:  model_store(psg_sel, d);
      OP_TICK:   model_tick();
      default: ;
    endcase
    r.read_data = psg_regs[psg_sel];
    r.amplitude = model_amplitude();
  endtask

  // One input beat, with an occasional idle burst in front of it.
  task automatic send_beat(input logic [1:0] op, input byte_t d);
    int          gap;
    psg_result_t r;
    if (source_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    data       <= d;
    do @(posedge clk); while (item_stall !== 1'b0);
    model_apply(op, d, r);
    expected_results.push_back(r);
    beats_sent++;
  endtask

  // Selects with random upper index bits, which the block must ignore.
  task automatic write_register(input logic [3:0] idx, input byte_t v);
    send_beat(OP_SELECT, {4'($urandom_range(0, 15)), idx});
    send_beat(OP_WRITE, v);
  endtask

  task automatic tick_burst(input int n);
    repeat (n) send_beat(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic shuffle_idling();
    source_gaps = ($urandom_range(0, 3) != 0);
    sink_gaps   = ($urandom_range(0, 3) != 0);
  endtask

  task automatic test_directed();
    send_beat(OP_READ, 8'hFF);
    send_beat(OP_SELECT, {4'hF, REG_VOL0});
    send_beat(OP_WRITE, 8'h0F);
    send_beat(OP_SELECT, {4'h0, REG_MIXER});
    send_beat(OP_WRITE, 8'hFF);
    send_beat(OP_TICK, 8'h00);
    // Zero periods are taken as one.
    send_beat(OP_SELECT, {4'h0, REG_TONE_LO0});
    send_beat(OP_WRITE, 8'h00);
    send_beat(OP_TICK, 8'hFF);
    send_beat(OP_SELECT, {4'hA, REG_NOISE});
    send_beat(OP_WRITE, 8'h00);
    send_beat(OP_SELECT, {4'h5, REG_ENV_LO});
    send_beat(OP_WRITE, 8'h00);
    send_beat(OP_SELECT, {4'h0, REG_ENV_HI});
    send_beat(OP_WRITE, 8'h00);
    send_beat(OP_SELECT, {4'h0, REG_SHAPE});
    send_beat(OP_WRITE, 8'h0E);
    send_beat(OP_SELECT, {4'h0, REG_VOL0 + 4'd1});
    send_beat(OP_WRITE, 8'h1F);
    send_beat(OP_TICK, 8'h00);
    send_beat(OP_TICK, 8'h00);
    send_beat(OP_READ, 8'h00);
    send_beat(OP_SELECT, {4'h0, REG_TONE_HI0});
    send_beat(OP_WRITE, 8'hFF);
    send_beat(OP_TICK, 8'h00);
  endtask

  task automatic test_register_file();
    shuffle_idling();
    repeat (100)
      send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic test_tone_noise();
    int    stop_at;
    int    ch;
    byte_t hi;
    stop_at = beats_sent + 250;
    write_register(REG_ENV_LO, 8'($urandom_range(0, 2)));
    write_register(REG_ENV_HI, 8'h00);
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: tick_burst($urandom_range(1, 30));
        5: shuffle_idling();
        6: begin
          // Mostly short periods, now and then a long one to be cut short.
          ch = $urandom_range(0, NUM_CH - 1);
          hi = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) != 0) hi[3:0] = 4'h0;
          write_register(REG_TONE_HI0 + 4'(2 * ch), hi);
          write_register(REG_TONE_LO0 + 4'(2 * ch), ($urandom_range(0, 3) == 0) ?
                         8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12)));
        end
        7: write_register(REG_NOISE, 8'($urandom_range(0, 255)));
        8: begin
          if ($urandom_range(0, 1) == 0)
            write_register(REG_MIXER, 8'($urandom_range(0, 255)));
          else
            write_register(REG_VOL0 + 4'($urandom_range(0, NUM_CH - 1)),
                           8'($urandom_range(0, 255)));
        end
        default: send_beat(OP_READ, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Runs one envelope shape well past its sixteenth step, with a stray
  // read or select now and then.
  task automatic envelope_run(input byte_t shape, input int ticks);
    write_register(REG_ENV_LO, 8'($urandom_range(0, 1)));
    write_register(REG_ENV_HI, 8'h00);
    write_register(REG_SHAPE, shape);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(($urandom_range(0, 1) == 0) ? OP_READ : OP_SELECT,
                  {4'($urandom_range(0, 15)), 4'($urandom_range(0, 12))});
      send_beat(OP_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_envelope();
    byte_t shape;
    shuffle_idling();
    write_register(REG_MIXER, 8'($urandom_range(0, 255)) | 8'h3B);
    write_register(REG_VOL0, 8'h10);
    write_register(REG_VOL0 + 4'd1, 8'h1F);
    write_register(REG_VOL0 + 4'd2, 8'($urandom_range(0, 31)));
    // Short runs where a shape write restarts the envelope part-way.
    repeat (4) begin
      write_register(REG_ENV_LO, 8'($urandom_range(0, 2)));
      write_register(REG_SHAPE, 8'($urandom_range(0, 255)));
      tick_burst($urandom_range(10, 30));
    end
    shape = 8'($urandom_range(0, 255));
    shape[SHAPE_CONT] = 1'b0;
    envelope_run(shape, 580);
    shuffle_idling();
    shape = 8'($urandom_range(0, 255));
    shape[SHAPE_CONT] = 1'b1;
    shape[SHAPE_HOLD] = 1'b1;
    envelope_run(shape, 580);
    // Final stretch runs without idling on either side.
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    shape = 8'($urandom_range(0, 255));
    shape[SHAPE_CONT] = 1'b1;
    shape[SHAPE_HOLD] = 1'b0;
    shape[SHAPE_ALT]  = 1'b1;
    envelope_run(shape, 600);
  endtask

  // Result side: checks each beat taken and drives random stall bursts.
  always @(posedge clk) begin : result_sink
    psg_result_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        if (failures < 10)
          $display("unexpected result beat: read_data %02h amplitude %0d",
                   read_data, amplitude);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (read_data !== want.read_data || amplitude !== want.amplitude) begin
          if (failures < 10)
            $display("result mismatch: read_data %02h (want %02h), amplitude %0d (want %0d)",
                     read_data, want.read_data, amplitude, want.amplitude);
          failures++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    vol_steps = '{0, 1, 2, 3, 4, 5, 7, 10, 13, 18, 24, 30, 36, 40, 42, 42};
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_for_results();
    test_register_file();
    wait_for_results();
    test_tone_noise();
    wait_for_results();
    test_envelope();
    wait_for_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/psg3_pkg.sv
design/psg3_tone.sv
design/psg3_noise.sv
design/psg3_env.sv
design/three_channel_tone_noise_envelope_psg.sv
tb/three_channel_tone_noise_envelope_psg_tb.sv
